// ===== rtl/core/load_module_record_parser_defines.svh =====
// Assertion macros for the load-module record parser.
// Included by files that carry concurrent assertions; needs clk and rst in scope.
`ifndef LOAD_MODULE_RECORD_PARSER_DEFINES_SVH
`define LOAD_MODULE_RECORD_PARSER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LMRP_ASSERT_NOW(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define LMRP_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

// ===== rtl/core/lmrp_pkg.sv =====
// Types and constants for the load-module record parser.
// No dependencies; imported by load_module_record_parser.
`default_nettype none

package lmrp_pkg;

  // Record codes
  localparam logic [7:0] CODE_DATA = 8'd1;
  localparam logic [7:0] CODE_EXEC = 8'd2;
  localparam logic [7:0] CODE_STOP = 8'd3;

  // Length byte of zero means 256
  localparam logic [8:0] LEN_FULL     = 9'h100;
  // Data lengths below three wrap: L - 2 + 256
  localparam logic [8:0] DATA_LEN_ADJ = 9'h0FE;
  localparam logic [8:0] ADDR_BYTES   = 9'd2;
  localparam logic [8:0] LEN_ONE      = 9'd1;
  localparam logic [8:0] LEN_TWO      = 9'd2;
  localparam logic [8:0] LEN_SHORT    = 9'd3;

  // Result kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_START = 1'b1;

  typedef enum logic [9:0] {
    PH_CODE    = 10'b00_0000_0001,
    PH_LEN     = 10'b00_0000_0010,
    PH_ADDR_LO = 10'b00_0000_0100,
    PH_ADDR_HI = 10'b00_0000_1000,
    PH_DATA    = 10'b00_0001_0000,
    PH_EXEC1   = 10'b00_0010_0000,
    PH_EXEC_LO = 10'b00_0100_0000,
    PH_EXEC_HI = 10'b00_1000_0000,
    PH_SKIP    = 10'b01_0000_0000,
    PH_HALT    = 10'b10_0000_0000
  } phase_t;

endpackage

`default_nettype wire

// ===== rtl/core/load_module_record_parser.sv =====
// Load-module record parser: byte stream in, memory writes and start address out.
// Depends on lmrp_pkg and load_module_record_parser_defines.svh.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------------
//   in      | into      | in_valid / in_stall   | file_byte, final_byte
//   out     | out of    | out_valid / out_stall | result_kind, target_address, write_data
//
// One byte per cycle unless a stalled output holds it back: an input register feeds
// the phase machine, whose result lands in the output register.
// rst is synchronous and active high; it returns the parser to expect record code.
// A stalled output only holds back bytes that produce a result; bytes that produce
// none keep flowing while a result waits.
`default_nettype none
`include "load_module_record_parser_defines.svh"

module load_module_record_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  file_byte,
  input  wire logic        final_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             result_kind,
  output logic [15:0]      target_address,
  output logic [7:0]       write_data
);

  import lmrp_pkg::*;

  // Input register
  logic       in_full;
  logic [7:0] in_byte;
  logic       in_final;

  // Parser state
  phase_t      phase, phase_next;
  logic [7:0]  record_code, record_code_next;
  logic [8:0]  bytes_remaining, bytes_remaining_next;
  logic [15:0] write_pointer, write_pointer_next;
  logic [7:0]  exec_low_byte, exec_low_byte_next;

  // Result of the current byte
  logic        emit;
  logic        emit_kind;
  logic [15:0] emit_addr;
  logic [7:0]  emit_data;

  logic [8:0]  len;
  logic        out_free;
  logic        step;

  assign out_free = !out_valid || !out_stall;
  assign step     = in_full && (!emit || out_free);
  assign in_stall = in_full && !step;

  assign len = (in_byte == 8'd0) ? LEN_FULL : {1'b0, in_byte};

  always_comb begin
    phase_next           = phase;
    record_code_next     = record_code;
    bytes_remaining_next = bytes_remaining;
    write_pointer_next   = write_pointer;
    exec_low_byte_next   = exec_low_byte;
    emit                 = 1'b0;
    emit_kind            = KIND_WRITE;
    emit_addr            = write_pointer;
    emit_data            = 8'd0;

    unique case (phase)
      PH_LEN: begin
        priority if (record_code == CODE_DATA) begin
          bytes_remaining_next = (len < LEN_SHORT) ? (len + DATA_LEN_ADJ)
                                                   : (len - ADDR_BYTES);
          phase_next = PH_ADDR_LO;
        end else if (record_code == CODE_EXEC) begin
          priority if (len == LEN_ONE) begin
            phase_next = PH_EXEC1;
          end else if (len == LEN_TWO) begin
            phase_next = PH_EXEC_LO;
          end else begin
            bytes_remaining_next = len;
            phase_next           = PH_SKIP;
          end
        end else if (record_code == CODE_STOP) begin
          phase_next = PH_HALT;
        end else begin
          bytes_remaining_next = len;
          phase_next           = PH_SKIP;
        end
      end
      PH_ADDR_LO: begin
        write_pointer_next = {write_pointer[15:8], in_byte};
        phase_next         = PH_ADDR_HI;
      end
      PH_ADDR_HI: begin
        write_pointer_next = {in_byte, write_pointer[7:0]};
        phase_next         = (bytes_remaining != 9'd0) ? PH_DATA : PH_CODE;
      end
      PH_DATA: begin
        emit                 = 1'b1;
        emit_kind            = KIND_WRITE;
        emit_addr            = write_pointer;
        emit_data            = in_byte;
        write_pointer_next   = write_pointer + 16'd1;
        bytes_remaining_next = bytes_remaining - 9'd1;
        if (bytes_remaining_next == 9'd0) begin
          phase_next = PH_CODE;
        end
      end
      PH_EXEC1: begin
        emit       = 1'b1;
        emit_kind  = KIND_START;
        emit_addr  = {8'd0, in_byte};
        phase_next = PH_CODE;
      end
      PH_EXEC_LO: begin
        exec_low_byte_next = in_byte;
        phase_next         = PH_EXEC_HI;
      end
      PH_EXEC_HI: begin
        emit       = 1'b1;
        emit_kind  = KIND_START;
        emit_addr  = {in_byte, exec_low_byte};
        phase_next = PH_CODE;
      end
      PH_SKIP: begin
        bytes_remaining_next = bytes_remaining - 9'd1;
        if (bytes_remaining_next == 9'd0) begin
          phase_next = PH_CODE;
        end
      end
      PH_HALT: begin
        phase_next = PH_HALT;
      end
      default: begin
        // expect record code; also catches stray encodings
        record_code_next = in_byte;
        phase_next       = PH_LEN;
      end
    endcase

    // last byte of the file rearms the parser
    if (in_final) begin
      phase_next           = PH_CODE;
      record_code_next     = 8'd0;
      bytes_remaining_next = 9'd0;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte  <= file_byte;
      in_final <= final_byte;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_CODE;
      record_code     <= 8'd0;
      bytes_remaining <= 9'd0;
      write_pointer   <= 16'd0;
      exec_low_byte   <= 8'd0;
    end else if (step) begin
      phase           <= phase_next;
      record_code     <= record_code_next;
      bytes_remaining <= bytes_remaining_next;
      write_pointer   <= write_pointer_next;
      exec_low_byte   <= exec_low_byte_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      result_kind    <= emit_kind;
      target_address <= emit_addr;
      write_data     <= emit_data;
    end
  end

  `LMRP_ASSERT_NOW(a_stall_needs_byte, in_stall, in_full, "in_stall without a held byte")
  `LMRP_ASSERT_NOW(a_start_zero_data, out_valid && (result_kind == KIND_START),
                   write_data == 8'd0, "start address with nonzero data")
  `LMRP_ASSERT_NEXT(a_pointer_advance, step && (phase == PH_DATA),
                    write_pointer == 16'($past(write_pointer) + 16'd1),
                    "write pointer did not advance after a data byte")
  `LMRP_ASSERT_NEXT(a_final_rearm, step && in_final,
                    (phase == PH_CODE) && (bytes_remaining == 9'd0) && (record_code == 8'd0),
                    "parser not rearmed after last byte")

endmodule

`default_nettype wire
